>>> rtl/core/wtc_pkg.sv
// Shared types, constants and helper functions of the waypoint thrust controller.
package wtc_pkg;

  localparam int WAYPOINT_DEPTH_DEF = 16;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_PREP, S_MUL, S_POST, S_SQRT, S_RGL,
    S_NORM, S_CORD, S_WRAP, S_ERR, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    ST_SQX, ST_SQY, ST_RG, ST_HG, ST_KP, ST_KI, ST_KDV, ST_KTP, ST_KDW
  } step_t;

  typedef enum logic [2:0] {
    REG_RANGE_GAIN, REG_HEADING_GAIN, REG_SPEED_PROP_GAIN, REG_SPEED_INT_GAIN,
    REG_DERIV_GAIN, REG_TURN_PROP_GAIN, REG_ARRIVE_RADIUS, REG_WAYPOINT_COUNT
  } reg_idx_t;

  localparam logic signed [31:0] RANGE_GAIN_RST      = 32'sd983040;
  localparam logic signed [31:0] HEADING_GAIN_RST    = 32'sd655360;
  localparam logic signed [31:0] SPEED_PROP_GAIN_RST = 32'sd32768000;
  localparam logic signed [31:0] SPEED_INT_GAIN_RST  = 32'sd0;
  localparam logic signed [31:0] DERIV_GAIN_RST      = 32'sd6553600;
  localparam logic signed [31:0] TURN_PROP_GAIN_RST  = 32'sd32768000;
  localparam logic [30:0]        ARRIVE_RADIUS_RST   = 31'd1310720;
  localparam logic [4:0]         WAYPOINT_COUNT_RST  = 5'd2;

  localparam logic signed [63:0] SPEED_MIN  = 64'sd131072;
  localparam logic signed [63:0] SPEED_MAX  = 64'sd655360;
  localparam logic signed [20:0] PI_Q16     = 21'sd205887;
  localparam logic signed [20:0] TWO_PI_Q16 = 21'sd411775;
  localparam logic signed [21:0] PI_Q18     = 22'sd823550;
  localparam logic [30:0]        RANGE_MAX  = 31'h7FFF_FFFF;
  localparam logic [4:0]         CORDIC_LAST = 5'd18;

  // arctan(2^-i) in units of 2^-18 rad
  function automatic logic [17:0] atan_entry(input logic [4:0] i);
    logic [17:0] e;
    case (i)
      5'd0:    e = 18'd205887;
      5'd1:    e = 18'd121542;
      5'd2:    e = 18'd64220;
      5'd3:    e = 18'd32599;
      5'd4:    e = 18'd16363;
      5'd5:    e = 18'd8189;
      5'd6:    e = 18'd4096;
      5'd7:    e = 18'd2048;
      5'd8:    e = 18'd1024;
      5'd9:    e = 18'd512;
      5'd10:   e = 18'd256;
      5'd11:   e = 18'd128;
      5'd12:   e = 18'd64;
      5'd13:   e = 18'd32;
      5'd14:   e = 18'd16;
      5'd15:   e = 18'd8;
      5'd16:   e = 18'd4;
      5'd17:   e = 18'd2;
      5'd18:   e = 18'd1;
      default: e = 18'd0;
    endcase
    return e;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/waypoint_thrust_controller.sv
// Waypoint thrust controller: go-to-goal steering, speed PID and yaw-rate PD.
//
// Input stream (in_*): one beat is an odometry sample (in_tuser = 0) or a
// waypoint write (in_tuser = 1). A sample yields one result beat on out_*,
// a waypoint write yields none. Gains, arrive radius and waypoint count sit
// behind the cfg_* register port and must be written while the block is idle;
// the block itself does not enforce this. A waypoint write is stored as it is
// accepted. A sample runs up to nine bit-serial multiplies on one shared
// shift-add unit, a restoring square root (two radicand bits a cycle), one-bit
// normalize shifts and 19 CORDIC iterations. A sample on a finished route goes
// straight to the output state. One item is in work at a time.
// The result sits in an output register; the next beat is taken while it
// waits. If the receiver stalls and a second result is ready, the sequencer
// holds in its output state until the register frees.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// the goal index, error history and integrator. Waypoint entries keep
// whatever they held and must be written before use.
module waypoint_thrust_controller #(
  parameter int WAYPOINT_DEPTH = wtc_pkg::WAYPOINT_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, yaw, speed, yaw_rate, waypoint_index, waypoint_x,
  // waypoint_y, one zero pad bit
  input  logic [215:0] in_tdata,
  // operation
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_thrust, right_thrust, range_to_goal, heading_error, goal_index,
  // route_done
  output logic [119:0] out_tdata
);
  import wtc_pkg::*;

  localparam int AW = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(WAYPOINT_DEPTH);

  // input beat fields
  logic signed [31:0] in_pos_x, in_pos_y, in_speed, in_yaw_rate, in_wp_x, in_wp_y;
  logic signed [18:0] in_yaw;
  logic [3:0]         in_wp_idx;
  assign in_pos_x    = in_tdata[31:0];
  assign in_pos_y    = in_tdata[63:32];
  assign in_yaw      = in_tdata[82:64];
  assign in_speed    = in_tdata[114:83];
  assign in_yaw_rate = in_tdata[146:115];
  assign in_wp_idx   = in_tdata[150:147];
  assign in_wp_x     = in_tdata[182:151];
  assign in_wp_y     = in_tdata[214:183];

  // registers behind the config port
  logic signed [31:0] range_gain_r, heading_gain_r, speed_prop_gain_r;
  logic signed [31:0] speed_int_gain_r, deriv_gain_r, turn_prop_gain_r;
  logic [30:0]        arrive_radius_r;
  logic [4:0]         waypoint_count_r;
  logic               cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (reg_idx_t'(cfg_paddr[4:2]))
      REG_RANGE_GAIN:      cfg_prdata = range_gain_r;
      REG_HEADING_GAIN:    cfg_prdata = heading_gain_r;
      REG_SPEED_PROP_GAIN: cfg_prdata = speed_prop_gain_r;
      REG_SPEED_INT_GAIN:  cfg_prdata = speed_int_gain_r;
      REG_DERIV_GAIN:      cfg_prdata = deriv_gain_r;
      REG_TURN_PROP_GAIN:  cfg_prdata = turn_prop_gain_r;
      REG_ARRIVE_RADIUS:   cfg_prdata = {1'b0, arrive_radius_r};
      REG_WAYPOINT_COUNT:  cfg_prdata = {27'd0, waypoint_count_r};
      default:             cfg_prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  state_t state_r, state_nxt;
  step_t  step_r;
  logic [4:0]  goal_r;
  logic signed [31:0] last_ev_r, last_ew_r;
  logic signed [47:0] sum_r;
  logic        out_valid_r;

  logic signed [31:0] pos_x_r, pos_y_r, speed_r, yaw_rate_r;
  logic signed [18:0] yaw_r;
  logic signed [32:0] dx_r, dy_r;
  logic [40:0]        ax_r, ay_r;
  logic [30:0]        rng_r;
  logic [19:0]        vset_r;
  logic signed [31:0] wset_r;
  logic signed [19:0] bearing_r;
  logic signed [18:0] alpha_r;
  logic signed [31:0] dv_r, dw_r, tv_r, tw_r;
  logic signed [65:0] tsum_r;
  logic [4:0]         cnt_r;

  // shift-add multiplier: one multiplier bit a cycle
  logic signed [79:0] mul_a_r, acc_r;
  logic [31:0]        mul_b_r;
  logic               mul_go, mul_clr;
  logic signed [47:0] mul_a;
  logic [31:0]        mul_b;

  // square root: two radicand bits a cycle
  logic [63:0] rad_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;

  // CORDIC vectoring
  logic signed [44:0] x_r, y_r;
  logic signed [21:0] cacc_r;

  // output register
  logic signed [31:0] o_left_r, o_right_r;
  logic [30:0]        o_range_r;
  logic signed [18:0] o_head_r;
  logic [4:0]         o_goal_r;
  logic               o_done_r;

  // waypoint memory
  logic [63:0] wp_mem [WAYPOINT_DEPTH];
  logic [63:0] mem_rdata_r;
  logic        mem_we;
  logic signed [31:0] wp_x_m, wp_y_m;

  assign wp_x_m = mem_rdata_r[63:32];
  assign wp_y_m = mem_rdata_r[31:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wp_mem[AW'(in_wp_idx)] <= {in_wp_x, in_wp_y};
    end
    mem_rdata_r <= wp_mem[AW'(goal_r)];
  end

  // route status
  logic [8:0] wc9, count9;
  logic       finished_c, accept_c, out_load;
  assign wc9        = {4'd0, waypoint_count_r};
  assign count9     = (wc9 > DEPTH9) ? DEPTH9 : wc9;
  assign finished_c = {4'd0, goal_r} >= count9;
  assign in_tready  = (state_r == S_IDLE);
  assign accept_c   = in_tvalid & in_tready;
  assign mem_we     = accept_c & in_tuser & ({5'd0, in_wp_idx} < DEPTH9);
  assign out_load   = (state_r == S_OUT) & (~out_valid_r | out_tready);

  // datapath combinational terms
  logic [32:0]        adx_c, ady_c;
  logic               big_c;
  logic signed [63:0] prod_q;
  logic signed [65:0] term_c;
  logic [35:0]        rem_sh, trial;
  logic               sq_ge;
  logic [31:0]        root_new;
  logic signed [44:0] xs, ys, x_n, y_n;
  logic signed [21:0] tab_c, a_n, a_rnd;
  logic signed [20:0] wa0, wa1, wa2;
  logic signed [18:0] alpha_c;
  logic [19:0]        vs_c;
  logic               arrive_c;
  logic signed [31:0] ev_c, ew_c, dv_c, dw_c;
  logic signed [48:0] sum49;
  logic signed [47:0] sum_c;

  always_comb begin
    adx_c  = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
    ady_c  = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
    big_c  = (|adx_c[32:31]) | (|ady_c[32:31]);
    prod_q = acc_r[79:16];
    term_c = 66'(prod_q);

    rem_sh   = {rem_r, rad_r[63:62]};
    trial    = {2'b00, root_r, 2'b01};
    sq_ge    = rem_sh >= trial;
    root_new = {root_r[30:0], sq_ge};

    xs    = x_r >>> cnt_r;
    ys    = y_r >>> cnt_r;
    tab_c = signed'({4'd0, atan_entry(cnt_r)});
    if (y_r[44]) begin
      x_n = x_r - ys;
      y_n = y_r + xs;
      a_n = cacc_r - tab_c;
    end else begin
      x_n = x_r + ys;
      y_n = y_r - xs;
      a_n = cacc_r + tab_c;
    end
    a_rnd = a_n + 22'sd2;

    // heading error: reduce toward zero by 2pi, then into [-pi, pi]
    wa0 = 21'(bearing_r) - 21'(yaw_r);
    if (wa0 >= TWO_PI_Q16) begin
      wa1 = wa0 - TWO_PI_Q16;
    end else if (wa0 <= -TWO_PI_Q16) begin
      wa1 = wa0 + TWO_PI_Q16;
    end else begin
      wa1 = wa0;
    end
    if (wa1 > PI_Q16) begin
      wa2 = wa1 - TWO_PI_Q16;
    end else if (wa1 < -PI_Q16) begin
      wa2 = wa1 + TWO_PI_Q16;
    end else begin
      wa2 = wa1;
    end
    alpha_c = wa2[18:0];

    arrive_c = rng_r < arrive_radius_r;
    vs_c     = arrive_c ? 20'd0 : vset_r;
    ev_c     = sat32(66'(signed'({1'b0, vs_c})) - 66'(speed_r));
    sum49    = 49'(sum_r) + 49'(ev_c);
    if (sum49[48] != sum49[47]) begin
      sum_c = sum49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      sum_c = sum49[47:0];
    end
    dv_c = sat32(66'(ev_c) - 66'(last_ev_r));
    ew_c = sat32(66'(wset_r) - 66'(yaw_rate_r));
    dw_c = sat32(66'(ew_c) - 66'(last_ew_r));
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and multiplier launch
  always_comb begin
    state_nxt = state_r;
    mul_go    = 1'b0;
    mul_clr   = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      S_IDLE: begin
        if (accept_c && !in_tuser) begin
          state_nxt = finished_c ? S_OUT : S_DIFF;
        end
      end
      S_DIFF: state_nxt = S_PREP;
      S_PREP: begin
        if (big_c) begin
          state_nxt = S_RGL;
        end else begin
          mul_go    = 1'b1;
          mul_clr   = 1'b1;
          mul_a     = {16'd0, adx_c[31:0]};
          mul_b     = adx_c[31:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (cnt_r == 5'd31) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        case (step_r)
          ST_SQX: begin
            mul_go    = 1'b1;
            mul_a     = {16'd0, ay_r[31:0]};
            mul_b     = ay_r[31:0];
            state_nxt = S_MUL;
          end
          ST_SQY: state_nxt = S_SQRT;
          ST_RG:  state_nxt = (dx_r == '0 && dy_r == '0) ? S_WRAP : S_NORM;
          ST_HG:  state_nxt = S_ERR;
          ST_KP: begin
            mul_go    = 1'b1;
            mul_clr   = 1'b1;
            mul_a     = sum_r;
            mul_b     = speed_int_gain_r;
            state_nxt = S_MUL;
          end
          ST_KI: begin
            mul_go    = 1'b1;
            mul_clr   = 1'b1;
            mul_a     = 48'(dv_r);
            mul_b     = deriv_gain_r;
            state_nxt = S_MUL;
          end
          ST_KDV: begin
            mul_go    = 1'b1;
            mul_clr   = 1'b1;
            mul_a     = 48'(last_ew_r);
            mul_b     = turn_prop_gain_r;
            state_nxt = S_MUL;
          end
          ST_KTP: begin
            mul_go    = 1'b1;
            mul_clr   = 1'b1;
            mul_a     = 48'(dw_r);
            mul_b     = deriv_gain_r;
            state_nxt = S_MUL;
          end
          ST_KDW:  state_nxt = S_OUT;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SQRT: begin
        if (cnt_r == 5'd31) begin
          state_nxt = S_RGL;
        end
      end
      S_RGL: begin
        mul_go    = 1'b1;
        mul_clr   = 1'b1;
        mul_a     = {17'd0, rng_r};
        mul_b     = range_gain_r;
        state_nxt = S_MUL;
      end
      S_NORM: begin
        if (ax_r[40] | ay_r[40]) begin
          state_nxt = S_CORD;
        end
      end
      S_CORD: begin
        if (cnt_r == CORDIC_LAST) begin
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        mul_go    = 1'b1;
        mul_clr   = 1'b1;
        mul_a     = 48'(alpha_c);
        mul_b     = heading_gain_r;
        state_nxt = S_MUL;
      end
      S_ERR: begin
        mul_go    = 1'b1;
        mul_clr   = 1'b1;
        mul_a     = 48'(ev_c);
        mul_b     = speed_prop_gain_r;
        state_nxt = S_MUL;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and registers with a reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_gain_r      <= RANGE_GAIN_RST;
      heading_gain_r    <= HEADING_GAIN_RST;
      speed_prop_gain_r <= SPEED_PROP_GAIN_RST;
      speed_int_gain_r  <= SPEED_INT_GAIN_RST;
      deriv_gain_r      <= DERIV_GAIN_RST;
      turn_prop_gain_r  <= TURN_PROP_GAIN_RST;
      arrive_radius_r   <= ARRIVE_RADIUS_RST;
      waypoint_count_r  <= WAYPOINT_COUNT_RST;
      goal_r            <= '0;
      last_ev_r         <= '0;
      last_ew_r         <= '0;
      sum_r             <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_RANGE_GAIN:      range_gain_r      <= cfg_pwdata;
          REG_HEADING_GAIN:    heading_gain_r    <= cfg_pwdata;
          REG_SPEED_PROP_GAIN: speed_prop_gain_r <= cfg_pwdata;
          REG_SPEED_INT_GAIN:  speed_int_gain_r  <= cfg_pwdata;
          REG_DERIV_GAIN:      deriv_gain_r      <= cfg_pwdata;
          REG_TURN_PROP_GAIN:  turn_prop_gain_r  <= cfg_pwdata;
          REG_ARRIVE_RADIUS:   arrive_radius_r   <= cfg_pwdata[30:0];
          REG_WAYPOINT_COUNT:  waypoint_count_r  <= cfg_pwdata[4:0];
          default: ;
        endcase
      end
      if (state_r == S_ERR) begin
        // error history and integrator advance once per sample not on a finished route
        last_ev_r <= ev_c;
        last_ew_r <= ew_c;
        sum_r     <= sum_c;
        if (arrive_c) begin
          goal_r <= goal_r + 5'd1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        pos_x_r    <= in_pos_x;
        pos_y_r    <= in_pos_y;
        yaw_r      <= in_yaw;
        speed_r    <= in_speed;
        yaw_rate_r <= in_yaw_rate;
        // finished route reports zeros
        tv_r       <= '0;
        tw_r       <= '0;
        rng_r      <= '0;
        alpha_r    <= '0;
      end
      S_DIFF: begin
        dx_r <= 33'(wp_x_m) - 33'(pos_x_r);
        dy_r <= 33'(wp_y_m) - 33'(pos_y_r);
      end
      S_PREP: begin
        ax_r   <= 41'(adx_c);
        ay_r   <= 41'(ady_c);
        rng_r  <= RANGE_MAX;
        step_r <= ST_SQX;
      end
      S_MUL: begin
        if (cnt_r == 5'd31) begin
          acc_r <= mul_b_r[0] ? acc_r - mul_a_r : acc_r;
        end else begin
          acc_r <= mul_b_r[0] ? acc_r + mul_a_r : acc_r;
        end
        mul_a_r <= mul_a_r <<< 1;
        mul_b_r <= mul_b_r >> 1;
        cnt_r   <= cnt_r + 5'd1;
      end
      S_POST: begin
        case (step_r)
          ST_SQX: step_r <= ST_SQY;
          ST_SQY: begin
            rad_r  <= acc_r[63:0];
            rem_r  <= '0;
            root_r <= '0;
            cnt_r  <= '0;
          end
          ST_RG: begin
            if (prod_q < SPEED_MIN) begin
              vset_r <= SPEED_MIN[19:0];
            end else if (prod_q > SPEED_MAX) begin
              vset_r <= SPEED_MAX[19:0];
            end else begin
              vset_r <= prod_q[19:0];
            end
            bearing_r <= '0;
            step_r    <= ST_HG;
          end
          ST_HG: wset_r <= sat32(term_c);
          ST_KP: begin
            tsum_r <= term_c;
            step_r <= ST_KI;
          end
          ST_KI: begin
            tsum_r <= tsum_r + term_c;
            step_r <= ST_KDV;
          end
          ST_KDV: begin
            tv_r   <= sat32(tsum_r + term_c);
            step_r <= ST_KTP;
          end
          ST_KTP: begin
            tsum_r <= term_c;
            step_r <= ST_KDW;
          end
          ST_KDW:  tw_r <= sat32(tsum_r + term_c);
          default: ;
        endcase
      end
      S_SQRT: begin
        rem_r  <= sq_ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        root_r <= root_new;
        rad_r  <= rad_r << 2;
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          rng_r <= root_new[31] ? RANGE_MAX : root_new[30:0];
        end
      end
      S_RGL: step_r <= ST_RG;
      S_NORM: begin
        if (ax_r[40] | ay_r[40]) begin
          // fold the left half plane onto the right, starting at +/-pi
          x_r <= 45'(ax_r);
          y_r <= (dx_r[32] ^ dy_r[32]) ? -45'(ay_r) : 45'(ay_r);
          if (dx_r[32]) begin
            cacc_r <= dy_r[32] ? -PI_Q18 : PI_Q18;
          end else begin
            cacc_r <= '0;
          end
          cnt_r <= '0;
        end else begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
        end
      end
      S_CORD: begin
        x_r    <= x_n;
        y_r    <= y_n;
        cacc_r <= a_n;
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == CORDIC_LAST) begin
          bearing_r <= a_rnd[21:2];
        end
      end
      S_WRAP: alpha_r <= alpha_c;
      S_ERR: begin
        dv_r   <= dv_c;
        dw_r   <= dw_c;
        step_r <= ST_KP;
      end
      S_OUT: begin
        if (out_load) begin
          o_left_r  <= sat32(66'(tv_r) - 66'(tw_r));
          o_right_r <= sat32(66'(tv_r) + 66'(tw_r));
          o_range_r <= rng_r;
          o_head_r  <= alpha_r;
          o_goal_r  <= goal_r;
          o_done_r  <= finished_c;
        end
      end
      default: ;
    endcase
    if (mul_go) begin
      mul_a_r <= 80'(mul_a);
      mul_b_r <= mul_b;
      cnt_r   <= '0;
      if (mul_clr) begin
        acc_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_done_r, o_goal_r, o_head_r, o_range_r, o_right_r, o_left_r};

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the waypoint thrust controller: streams, registers, checks.
`timescale 1ns / 1ps

module tb_top;
  import wtc_pkg::*;

  localparam int DEPTH      = 16;
  localparam int WATCH_MAX  = 20000; // cycles without any beat before giving up
  localparam int HOLD_LEN   = 3000;  // long receiver hold-off
  localparam longint Q_MAX  = 64'sd2147483647;
  localparam longint Q_MIN  = -64'sd2147483648;
  localparam longint S48_MAX = 64'sd140737488355327;
  localparam longint S48_MIN = -64'sd140737488355328;
  localparam bit OP_SAMPLE   = 1'b0;
  localparam bit OP_WAYPOINT = 1'b1;

  typedef struct {
    bit          op;
    int          px, py;
    int          yaw;
    int          spd, yrate;
    bit [3:0]    widx;
    int          wx, wy;
  } odo_t;

  typedef struct {
    bit [31:0] left, right;
    bit [30:0] rng;
    bit [18:0] hdg;
    bit [4:0]  goal;
    bit        done;
  } thrust_t;

  logic         clk, rst_n;
  logic         cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  logic         in_tvalid, in_tready;
  // pos_x, pos_y, yaw, speed, yaw_rate, waypoint_index, waypoint_x, waypoint_y, pad
  logic [215:0] in_tdata;
  // operation
  logic         in_tuser;
  logic         out_tvalid, out_tready;
  // left_thrust, right_thrust, range_to_goal, heading_error, goal_index, route_done
  logic [119:0] out_tdata;

  waypoint_thrust_controller DUT (.*);

  // shadow registers and controller state
  longint k_range, k_head, k_sp, k_si, k_d, k_tp, radius;
  int unsigned wp_count;
  longint wp_x[DEPTH], wp_y[DEPTH];
  int unsigned goal;
  longint prev_ev, prev_ew, ev_sum;

  odo_t    pending[$];
  odo_t    cur;
  thrust_t thrust_due[$];
  int      fails;
  int      send_idle, recv_stall;
  bit      hold_arm, hold_done;
  int      hold_cnt, watch;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor(a*b / 2^16) without overflowing 64 bits
  function automatic longint qmul(longint a, longint b);
    longint hi, lo;
    hi = a >>> 16;
    lo = a - hi * 65536;
    return hi * b + ((lo * b) >>> 16);
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  // CORDIC bearing, angle units 2^-18 rad inside, Q16.16 out
  function automatic longint bearing(longint dx, longint dy);
    longint unsigned ax, ay, m;
    longint x, y, acc, xs, ys;
    longint tab[19] = '{205887, 121542, 64220, 32599, 16363, 8189, 4096, 2048, 1024,
                        512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    int sh;
    if (dx == 0 && dy == 0) return 0;
    ax = absl(dx);
    ay = absl(dy);
    m = ax > ay ? ax : ay;
    sh = 0;
    while ((m << sh) < (64'd1 << 40)) sh++;
    x = ax << sh;
    y = ay << sh;
    if (dx < 0) x = -x;
    if (dy < 0) y = -y;
    acc = 0;
    if (x < 0) begin
      acc = (y >= 0) ? 823550 : -823550;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 19; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x -= ys; y += xs; acc -= tab[i];
      end else begin
        x += ys; y -= xs; acc += tab[i];
      end
    end
    return (acc + 2) >>> 2;
  endfunction

  function automatic int unsigned route_len();
    return wp_count > DEPTH ? DEPTH : wp_count;
  endfunction

  // advance the controller model by one beat; returns 1 when a result is due
  function automatic bit steer_step(odo_t it, output thrust_t r);
    longint dx, dy, rng, alpha, vset, wset, ev, dv, ew, dw, tv, tw;
    longint unsigned adx, ady, rt;
    r = '{default: 0};
    if (it.op == OP_WAYPOINT) begin
      wp_x[it.widx] = it.wx;
      wp_y[it.widx] = it.wy;
      return 0;
    end
    if (goal >= route_len()) begin
      r.goal = goal[4:0];
      r.done = 1;
      return 1;
    end
    dx = wp_x[goal] - longint'(it.px);
    dy = wp_y[goal] - longint'(it.py);
    adx = absl(dx);
    ady = absl(dy);
    if (adx >= (64'd1 << 31) || ady >= (64'd1 << 31)) begin
      rng = Q_MAX;
    end else begin
      rt = root64(adx * adx + ady * ady);
      rng = rt > Q_MAX ? Q_MAX : longint'(rt);
    end
    vset = clip((k_range * rng) >>> 16, 131072, 655360);
    alpha = (bearing(dx, dy) - longint'(it.yaw)) % 411775;
    if (alpha > 205887) alpha -= 411775;
    else if (alpha < -205887) alpha += 411775;
    wset = clip(qmul(alpha, k_head), Q_MIN, Q_MAX);
    if (rng < radius) begin
      vset = 0;
      goal++;
    end
    ev = clip(vset - longint'(it.spd), Q_MIN, Q_MAX);
    ev_sum = clip(ev_sum + ev, S48_MIN, S48_MAX);
    dv = clip(ev - prev_ev, Q_MIN, Q_MAX);
    tv = clip(qmul(ev, k_sp) + qmul(ev_sum, k_si) + qmul(dv, k_d), Q_MIN, Q_MAX);
    ew = clip(wset - longint'(it.yrate), Q_MIN, Q_MAX);
    dw = clip(ew - prev_ew, Q_MIN, Q_MAX);
    tw = clip(qmul(ew, k_tp) + qmul(dw, k_d), Q_MIN, Q_MAX);
    prev_ev = ev;
    prev_ew = ew;
    r.left  = clip(tv - tw, Q_MIN, Q_MAX);
    r.right = clip(tv + tw, Q_MIN, Q_MAX);
    r.rng   = rng[30:0];
    r.hdg   = alpha[18:0];
    r.goal  = goal[4:0];
    r.done  = goal >= route_len();
    return 1;
  endfunction

  task automatic report(string what, longint got, longint want);
    fails++;
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver: next beat when the current one is taken or the bus is empty
  always @(posedge clk) begin
    thrust_t r;
    odo_t    nx;
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_tvalid && in_tready && steer_step(cur, r)) thrust_due.push_back(r);
      if (!in_tvalid || in_tready) begin
        if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          nx = pending.pop_front();
          cur <= nx;
          in_tvalid <= 1;
          in_tuser  <= nx.op;
          in_tdata  <= {1'b0, nx.wy, nx.wx, nx.widx, nx.yrate, nx.spd, nx.yaw[18:0],
                        nx.py, nx.px};
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // receiver back-pressure, with a single long hold-off when armed
  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN) hold_done <= 1;
    end
    out_tready <= rst_n && !(hold_arm && !hold_done) &&
                  $urandom_range(0, 99) >= recv_stall;
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    thrust_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (thrust_due.size() == 0) begin
        fails++;
        $display("%0t result beat with nothing expected", $realtime);
      end else begin
        e = thrust_due.pop_front();
        if (out_tdata[31:0] != e.left)
          report("left_thrust", $signed(out_tdata[31:0]), $signed(e.left));
        if (out_tdata[63:32] != e.right)
          report("right_thrust", $signed(out_tdata[63:32]), $signed(e.right));
        if (out_tdata[94:64] != e.rng) report("range_to_goal", out_tdata[94:64], e.rng);
        if (out_tdata[113:95] != e.hdg)
          report("heading_error", $signed(out_tdata[113:95]), $signed(e.hdg));
        if (out_tdata[118:114] != e.goal) report("goal_index", out_tdata[118:114], e.goal);
        if (out_tdata[119] != e.done) report("route_done", out_tdata[119], e.done);
      end
    end
  end

  // watchdog on beats of either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      watch <= 0;
    end else if (watch >= WATCH_MAX) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      watch <= watch + 1;
    end
  end

  task automatic reg_write(reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    cfg_psel    <= 1;
    cfg_penable <= 0;
    cfg_pwrite  <= 1;
    cfg_paddr   <= 5'(r) << 2;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    case (r)
      REG_RANGE_GAIN:      k_range  = longint'(signed'(v));
      REG_HEADING_GAIN:    k_head   = longint'(signed'(v));
      REG_SPEED_PROP_GAIN: k_sp     = longint'(signed'(v));
      REG_SPEED_INT_GAIN:  k_si     = longint'(signed'(v));
      REG_DERIV_GAIN:      k_d      = longint'(signed'(v));
      REG_TURN_PROP_GAIN:  k_tp     = longint'(signed'(v));
      REG_ARRIVE_RADIUS:   radius   = v[30:0];
      REG_WAYPOINT_COUNT:  wp_count = v[4:0];
      default: ;
    endcase
  endtask

  task automatic gains(int rg, int hg, int sp, int si, int kd, int tp);
    reg_write(REG_RANGE_GAIN, rg);
    reg_write(REG_HEADING_GAIN, hg);
    reg_write(REG_SPEED_PROP_GAIN, sp);
    reg_write(REG_SPEED_INT_GAIN, si);
    reg_write(REG_DERIV_GAIN, kd);
    reg_write(REG_TURN_PROP_GAIN, tp);
  endtask

  // wait for the block to drain before touching registers
  task automatic settle();
    while (pending.size() > 0 || in_tvalid || thrust_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int rnd_small();
    return int'($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  function automatic int rnd_yaw();
    return int'($urandom_range(0, 411774)) - 205887;
  endfunction

  function automatic odo_t sample(int px, int py, int yaw, int spd, int yr);
    odo_t it;
    it = '{op: OP_SAMPLE, px: px, py: py, yaw: yaw, spd: spd, yrate: yr,
           widx: $urandom, wx: $urandom, wy: $urandom};
    return it;
  endfunction

  function automatic odo_t waypoint(int idx, int x, int y);
    odo_t it;
    it = '{op: OP_WAYPOINT, px: $urandom, py: $urandom, yaw: rnd_yaw(), spd: $urandom,
           yrate: $urandom, widx: idx, wx: x, wy: y};
    return it;
  endfunction

  // mostly well-formed traffic steering around the current goal
  function automatic odo_t make_item();
    int k, sel, tx, ty, spd, yr;
    k = goal < DEPTH ? goal : $urandom_range(0, DEPTH - 1);
    tx = wp_x[k];
    ty = wp_y[k];
    if ($urandom_range(0, 99) < 8)
      return waypoint($urandom_range(0, DEPTH - 1), rnd_small() <<< $urandom_range(0, 4),
                      rnd_small() <<< $urandom_range(0, 4));
    sel = $urandom_range(0, 99);
    spd = $urandom_range(0, 3) == 0 ? $urandom : rnd_small();
    yr  = $urandom_range(0, 3) == 0 ? $urandom : rnd_small();
    if (sel < 3)
      return sample(tx + int'($urandom_range(0, 1 << 19)) - (1 << 18),
                    ty + int'($urandom_range(0, 1 << 19)) - (1 << 18), rnd_yaw(), spd, yr);
    if (sel < 75)
      return sample(tx + (rnd_small() <<< $urandom_range(0, 4)),
                    ty + (rnd_small() <<< $urandom_range(0, 4)), rnd_yaw(), spd, yr);
    if (sel < 92) return sample($urandom, $urandom, rnd_yaw(), $urandom, $urandom);
    return sample($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                  $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                  $urandom_range(0, 1) ? 205887 : -205887,
                  $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                  $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
  endfunction

  task automatic run_phase(int n, int s_idle, int r_stall, bit hold);
    send_idle  = s_idle;
    recv_stall = r_stall;
    if (hold) hold_arm = 1;
    for (int i = 0; i < n; i++) begin
      while (pending.size() >= 2) @(posedge clk);
      pending.push_back(make_item());
    end
    settle();
  endtask

  initial begin
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    in_tvalid = 0; in_tuser = 0; in_tdata = '0; out_tready = 0;
    rst_n = 0;
    fails = 0; watch = 0; send_idle = 0; recv_stall = 0;
    hold_arm = 0; hold_done = 0; hold_cnt = 0;
    k_range = 983040; k_head = 655360; k_sp = 32768000; k_si = 0;
    k_d = 6553600; k_tp = 32768000; radius = 1310720; wp_count = 2;
    goal = 0; prev_ev = 0; prev_ew = 0; ev_sum = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: fill the whole table first, extremes at the first entries
    pending.push_back(waypoint(0, 32'h7FFF_FFFF, 32'h8000_0000));
    pending.push_back(waypoint(1, 32'h8000_0000, 32'h7FFF_FFFF));
    for (int i = 2; i < DEPTH; i++)
      pending.push_back(waypoint(i, rnd_small() <<< 3, rnd_small() <<< 3));
    // far out of range and dead on each waypoint in turn (zero vector, arrival)
    pending.push_back(sample(32'h8000_0000, 32'h7FFF_FFFF, 205887, 32'h7FFF_FFFF, 0));
    pending.push_back(sample(32'h7FFF_FFFF, 32'h8000_0000, -205887, 32'h8000_0000,
                             32'h7FFF_FFFF));
    pending.push_back(sample(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h8000_0000));
    pending.push_back(sample(0, 0, 205887, 32'h8000_0000, 32'h8000_0000));
    pending.push_back(sample(32'h8000_0000, 32'h7FFF_FFFF, -205887, 0, 0));
    // goal index now at the route end: finished-route reports
    pending.push_back(sample(0, 0, 0, 0, 0));
    settle();

    // a zero route length finishes at once
    reg_write(REG_WAYPOINT_COUNT, 0);
    pending.push_back(sample($urandom, $urandom, rnd_yaw(), $urandom, $urandom));
    settle();

    reg_write(REG_WAYPOINT_COUNT, 5);
    run_phase(250, 0, 0, 0);

    gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF);
    reg_write(REG_ARRIVE_RADIUS, 0);
    reg_write(REG_WAYPOINT_COUNT, 8);
    run_phase(200, 86, 0, 0);

    gains($urandom, $urandom, $urandom, rnd_small(), $urandom, $urandom);
    reg_write(REG_ARRIVE_RADIUS, 1310720);
    run_phase(250, 0, 86, 0);

    gains(983040, 655360, 32768000, 6553, 6553600, 32768000);
    reg_write(REG_WAYPOINT_COUNT, 12);
    run_phase(250, 29, 29, 1);

    gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000);
    reg_write(REG_WAYPOINT_COUNT, 16);
    reg_write(REG_ARRIVE_RADIUS, 4 << 16);
    run_phase(250, 0, 0, 0);

    // widest radius walks the rest of the route; count above depth clamps
    gains(983040, 655360, 32768000, 0, 6553600, 32768000);
    reg_write(REG_ARRIVE_RADIUS, 32'h7FFF_FFFF);
    reg_write(REG_WAYPOINT_COUNT, 31);
    run_phase(150, 29, 29, 0);

    repeat (400) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
